// ===== src/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg: shared definitions for the path policy checker
// Reason codes, byte-level fault codes and the fixed path patterns that the
// checker compares against.
// ----------------------------------------------------------------------------
package ppc_pkg;

	// Verdict reason codes, as seen on the reason port.
	typedef enum logic [3:0] {
		RSN_OK           = 4'd0,
		RSN_EMPTY        = 4'd1,
		RSN_UNROOTED     = 4'd2,
		RSN_TOO_LONG     = 4'd3,
		RSN_BACKSLASH    = 4'd4,
		RSN_CONTROL      = 4'd5,
		RSN_EMPTY_SEG    = 4'd6,
		RSN_TRAVERSAL    = 4'd7,
		RSN_TIER2_CONFIG = 4'd8,
		RSN_NOT_LISTABLE = 4'd9,
		RSN_READ_LIMIT   = 4'd10,
		RSN_LOG_WRITE    = 4'd11,
		RSN_WRITE_LIMIT  = 4'd12,
		RSN_DELETE_LIMIT = 4'd13
	} reason_t;

	// Earliest byte-level fault; the code equals the low bits of the reason.
	typedef enum logic [2:0] {
		FLT_NONE      = 3'd0,
		FLT_UNROOTED  = 3'd2,
		FLT_BACKSLASH = 3'd4,
		FLT_CONTROL   = 3'd5,
		FLT_EMPTY_SEG = 3'd6
	} fault_t;

	// Operation codes.
	typedef enum logic [1:0] {
		OP_LIST   = 2'd0,
		OP_READ   = 2'd1,
		OP_WRITE  = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	// Pattern flags: index of each fixed-string match bit.
	localparam int PAT_COUNT      = 6;
	localparam int PAT_IN_LOGS    = 0;
	localparam int PAT_IN_TABLES  = 1;
	localparam int PAT_IN_CONFIG  = 2;
	localparam int PAT_IS_CFGJSON = 3;
	localparam int PAT_IS_LOGS    = 4;
	localparam int PAT_IS_TABLES  = 5;

	localparam int PAT_TEXT_W = 96;

	// Pattern text, left aligned and zero padded to twelve characters.
	localparam logic [PAT_TEXT_W-1:0] TXT_LOGS    = {"/logs/", 48'h0};
	localparam logic [PAT_TEXT_W-1:0] TXT_TABLES  = {"/tables/", 32'h0};
	localparam logic [PAT_TEXT_W-1:0] TXT_CONFIG  = {"/config/", 32'h0};
	localparam logic [PAT_TEXT_W-1:0] TXT_CFGJSON = "/config.json";

	localparam logic [PAT_TEXT_W-1:0] PAT_TEXT [PAT_COUNT] = '{
		TXT_LOGS, TXT_TABLES, TXT_CONFIG, TXT_CFGJSON, TXT_LOGS, TXT_TABLES
	};
	localparam logic [7:0] PAT_LEN [PAT_COUNT] = '{
		8'd6, 8'd8, 8'd8, 8'd12, 8'd6, 8'd8
	};
	localparam logic [PAT_COUNT-1:0] PAT_EXACT = 6'b111000;

	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DEL       = 8'h7F;

	// Character at position idx of a left-aligned pattern text.
	function automatic logic [7:0] pat_byte(input logic [PAT_TEXT_W-1:0] txt,
			input logic [3:0] idx);
		logic [PAT_TEXT_W-1:0] sh;
		sh = txt << {idx, 3'b000};
		return sh[PAT_TEXT_W-1 -: 8];
	endfunction

endpackage

// ===== src/path_policy_checker_top.sv =====
// ----------------------------------------------------------------------------
// path_policy_checker_top: streaming path access policy checker
// A path arrives one byte per beat; one verdict beat leaves per path.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle while the input is not
// stalled, with no gaps required. The verdict for a path is worked out from
// the beat marked last once it sits in the input register, and is then
// loaded into the result register that drives the output.
// The rate is set by the single registered pass per byte, which updates the
// length counter, the fault and segment trackers and six pattern match
// flags. The input is stalled only while the result register holds an
// untaken verdict and the beat in the input register would produce another
// one. Beats without a byte and without last are absorbed silently.
module path_policy_checker_top #(
	parameter int MAX_PATH_LEN = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] path_byte,
	input  logic       has_byte,
	input  logic       last,
	input  logic [1:0] op,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       allowed,
	output logic [3:0] reason
);
	import ppc_pkg::*;

	localparam logic [7:0] MAX_LEN = 8'(MAX_PATH_LEN);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;
	logic [1:0] op_s1;
	logic       go_s1;

	// Per-path state.
	logic [7:0]           count_q;
	fault_t               fault_q;
	logic                 slash_q;
	logic [1:0]           seglen_q;
	logic                 dots_q;
	logic                 trav_q;
	logic [PAT_COUNT-1:0] match_q;

	// Result register.
	logic    out_valid_q;
	logic    allowed_q;
	reason_t reason_q;

	// Next state after the byte in the input register, and its verdict.
	logic [7:0]           count_n;
	fault_t               fault_n;
	logic                 slash_n;
	logic [1:0]           seglen_n;
	logic                 dots_n;
	logic                 trav_n;
	logic [PAT_COUNT-1:0] match_n;
	logic [PAT_COUNT-1:0] hit;
	logic                 trav_final;
	reason_t              verdict;

	// The input beat moves on unless it would overwrite a held verdict.
	assign go_s1    = !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= path_byte;
			has_s1  <= has_byte;
			last_s1 <= last;
			op_s1   <= op;
		end
	end

	// Byte update: patterns, first fault, segment tracking and length.
	always_comb begin
		count_n  = count_q;
		fault_n  = fault_q;
		slash_n  = slash_q;
		seglen_n = seglen_q;
		dots_n   = dots_q;
		trav_n   = trav_q;
		match_n  = match_q;
		if (has_s1) begin
			for (int k = 0; k < PAT_COUNT; k++) begin
				if (count_q < PAT_LEN[k] &&
						byte_s1 != pat_byte(PAT_TEXT[k], count_q[3:0])) begin
					match_n[k] = 1'b0;
				end
			end
			if (fault_q == FLT_NONE) begin
				if (count_q == 8'd0 && byte_s1 != CH_SLASH) begin
					fault_n = FLT_UNROOTED;
				end else if (byte_s1 == CH_BACKSLASH) begin
					fault_n = FLT_BACKSLASH;
				end else if (byte_s1 < CH_SPACE || byte_s1 == CH_DEL) begin
					fault_n = FLT_CONTROL;
				end else if (byte_s1 == CH_SLASH && slash_q) begin
					fault_n = FLT_EMPTY_SEG;
				end
			end
			if (count_q == 8'd0) begin
				seglen_n = 2'd0;
				dots_n   = 1'b1;
			end else if (byte_s1 == CH_SLASH) begin
				if (seglen_q == 2'd2 && dots_q) begin
					trav_n = 1'b1;
				end
				seglen_n = 2'd0;
				dots_n   = 1'b1;
			end else begin
				if (seglen_q != 2'd3) begin
					seglen_n = seglen_q + 2'd1;
				end
				if (byte_s1 != CH_DOT) begin
					dots_n = 1'b0;
				end
			end
			slash_n = (byte_s1 == CH_SLASH);
			if (count_q != 8'hFF) begin
				count_n = count_q + 8'd1;
			end
		end
	end

	// Pattern hits: exact patterns need the full length, prefixes at least it.
	always_comb begin
		for (int k = 0; k < PAT_COUNT; k++) begin
			if (PAT_EXACT[k]) begin
				hit[k] = match_n[k] && (count_n == PAT_LEN[k]);
			end else begin
				hit[k] = match_n[k] && (count_n >= PAT_LEN[k]);
			end
		end
	end

	// The last segment closes at the end of the path too.
	assign trav_final = trav_n ||
		(count_n > 8'd1 && seglen_n == 2'd2 && dots_n);

	// Verdict: structural checks in priority order, then the operation rule.
	always_comb begin
		if (count_n == 8'd0) begin
			verdict = RSN_EMPTY;
		end else if (fault_n == FLT_UNROOTED) begin
			verdict = RSN_UNROOTED;
		end else if (count_n > MAX_LEN) begin
			verdict = RSN_TOO_LONG;
		end else if (fault_n != FLT_NONE) begin
			verdict = reason_t'({1'b0, fault_n});
		end else if (trav_final) begin
			verdict = RSN_TRAVERSAL;
		end else begin
			case (op_t'(op_s1))
				OP_LIST: begin
					if (hit[PAT_IS_LOGS] || hit[PAT_IS_TABLES]) begin
						verdict = RSN_OK;
					end else begin
						verdict = hit[PAT_IN_CONFIG] ? RSN_TIER2_CONFIG : RSN_NOT_LISTABLE;
					end
				end
				OP_READ: begin
					if (hit[PAT_IN_LOGS]) begin
						verdict = RSN_OK;
					end else begin
						verdict = hit[PAT_IN_CONFIG] ? RSN_TIER2_CONFIG : RSN_READ_LIMIT;
					end
				end
				OP_WRITE: begin
					if (hit[PAT_IN_TABLES] || hit[PAT_IS_CFGJSON]) begin
						verdict = RSN_OK;
					end else begin
						verdict = hit[PAT_IN_LOGS] ? RSN_LOG_WRITE : RSN_WRITE_LIMIT;
					end
				end
				default: begin
					verdict = hit[PAT_IN_LOGS] ? RSN_OK : RSN_DELETE_LIMIT;
				end
			endcase
		end
	end

	// Per-path state: advance on every beat, back to reset after a last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 8'd0;
			fault_q  <= FLT_NONE;
			slash_q  <= 1'b0;
			seglen_q <= 2'd0;
			dots_q   <= 1'b1;
			trav_q   <= 1'b0;
			match_q  <= '1;
		end else if (valid_s1 && go_s1) begin
			if (last_s1) begin
				count_q  <= 8'd0;
				fault_q  <= FLT_NONE;
				slash_q  <= 1'b0;
				seglen_q <= 2'd0;
				dots_q   <= 1'b1;
				trav_q   <= 1'b0;
				match_q  <= '1;
			end else begin
				count_q  <= count_n;
				fault_q  <= fault_n;
				slash_q  <= slash_n;
				seglen_q <= seglen_n;
				dots_q   <= dots_n;
				trav_q   <= trav_n;
				match_q  <= match_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go_s1 && last_s1) begin
			reason_q  <= verdict;
			allowed_q <= (verdict == RSN_OK);
		end
	end

	assign out_valid = out_valid_q;
	assign allowed   = allowed_q;
	assign reason    = 4'(reason_q);

endmodule

// ===== src/ppc_checker.sv =====
// ----------------------------------------------------------------------------
// ppc_checker: port-level assertions for the path policy checker
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module ppc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] path_byte,
	input logic       has_byte,
	input logic       last,
	input logic [1:0] op,
	input logic       out_valid,
	input logic       out_stall,
	input logic       allowed,
	input logic [3:0] reason
);
	import ppc_pkg::*;

	// A stalled input beat stays on the input unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(path_byte) &&
			$stable(has_byte) && $stable(last) && $stable(op))
		else $error("input beat changed while stalled");

	// A stalled verdict beat stays on the output unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reason) && $stable(allowed))
		else $error("verdict beat changed while stalled");

	// Allowed is exactly the ok reason.
	a_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> allowed == (reason == 4'(RSN_OK)))
		else $error("allowed disagrees with reason");

	// Only defined reason codes leave the block.
	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reason <= 4'(RSN_DELETE_LIMIT))
		else $error("reason code out of range");

	// The input is held back only while a verdict waits on the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule

bind path_policy_checker_top ppc_checker u_ppc_checker (.*);

// ===== tb/path_policy_checker_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_policy_checker_chk: verdict scoreboard for the path policy checker
// Watches both channels, keeps its own copy of the per-path trackers, works
// out the verdict for every path that ends on an accepted beat and compares
// each accepted verdict beat with the oldest one still waiting.
// ----------------------------------------------------------------------------
module path_policy_checker_chk #(
	parameter int MAX_PATH_LEN = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  path_byte,
	input  logic        has_byte,
	input  logic        last,
	input  logic [1:0]  op,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        allowed,
	input  logic [3:0]  reason,
	output int          errors,
	output int          pending,
	output int          verdicts,
	output logic [13:0] reasons_seen
);
	import ppc_pkg::*;

	// Per-path trackers of the prediction.
	logic [7:0]           n_bytes;
	fault_t               fault;
	logic                 prev_slash;
	logic [1:0]           seg_len;
	logic                 seg_dots;
	logic                 dotdot_seen;
	logic [PAT_COUNT-1:0] pat_ok;

	// Verdicts of finished paths, oldest first.
	reason_t verdict_q[$];

	// One line per mismatch; printing stops after the first hundred.
	task automatic report(input string msg);
		errors++;
		if (errors <= 100)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Fixed text behind each match flag.
	function automatic string pattern_text(input int k);
		case (k)
			PAT_IN_LOGS, PAT_IS_LOGS:     return "/logs/";
			PAT_IN_TABLES, PAT_IS_TABLES: return "/tables/";
			PAT_IN_CONFIG:                return "/config/";
			default:                      return "/config.json";
		endcase
	endfunction

	function automatic void clear_path();
		n_bytes     = '0;
		fault       = FLT_NONE;
		prev_slash  = 1'b0;
		seg_len     = '0;
		seg_dots    = 1'b1;
		dotdot_seen = 1'b0;
		pat_ok      = '1;
	endfunction

	// A segment that is exactly two dots marks the path as a traversal.
	function automatic void end_segment();
		if (seg_len == 2'd2 && seg_dots)
			dotdot_seen = 1'b1;
		seg_len  = '0;
		seg_dots = 1'b1;
	endfunction

	// Fold one path byte into the trackers.
	function automatic void absorb_byte(input logic [7:0] c);
		string s;
		int    k;
		int    idx;
		idx = n_bytes;
		for (k = 0; k < PAT_COUNT; k++) begin
			s = pattern_text(k);
			if (idx < s.len() && c != s[idx])
				pat_ok[k] = 1'b0;
		end
		if (fault == FLT_NONE) begin
			if (idx == 0 && c != CH_SLASH)
				fault = FLT_UNROOTED;
			else if (c == CH_BACKSLASH)
				fault = FLT_BACKSLASH;
			else if (c < CH_SPACE || c == CH_DEL)
				fault = FLT_CONTROL;
			else if (c == CH_SLASH && prev_slash)
				fault = FLT_EMPTY_SEG;
		end
		if (idx == 0) begin
			seg_len  = '0;
			seg_dots = 1'b1;
		end else if (c == CH_SLASH) begin
			end_segment();
		end else begin
			if (seg_len != 2'd3)
				seg_len++;
			if (c != CH_DOT)
				seg_dots = 1'b0;
		end
		prev_slash = (c == CH_SLASH);
		if (n_bytes != 8'hFF)
			n_bytes++;
	endfunction

	// Prefix flags need at least the pattern length, exact flags exactly it.
	function automatic logic pattern_hit(input int k);
		string s;
		s = pattern_text(k);
		if (!pat_ok[k])
			return 1'b0;
		if (k == PAT_IS_CFGJSON || k == PAT_IS_LOGS || k == PAT_IS_TABLES)
			return n_bytes == s.len();
		return n_bytes >= s.len();
	endfunction

	// Structural checks in priority order, then the per-operation rule.
	function automatic reason_t judge_path(input op_t o);
		logic in_logs;
		logic in_tables;
		logic in_config;
		logic is_cfgjson;
		logic is_logs;
		logic is_tables;
		if (n_bytes == 0)
			return RSN_EMPTY;
		if (fault == FLT_UNROOTED)
			return RSN_UNROOTED;
		if (n_bytes > MAX_PATH_LEN)
			return RSN_TOO_LONG;
		case (fault)
			FLT_BACKSLASH: return RSN_BACKSLASH;
			FLT_CONTROL:   return RSN_CONTROL;
			FLT_EMPTY_SEG: return RSN_EMPTY_SEG;
			default: ;
		endcase
		// A trailing segment without a closing slash still counts.
		if (n_bytes > 1)
			end_segment();
		if (dotdot_seen)
			return RSN_TRAVERSAL;
		in_logs    = pattern_hit(PAT_IN_LOGS);
		in_tables  = pattern_hit(PAT_IN_TABLES);
		in_config  = pattern_hit(PAT_IN_CONFIG);
		is_cfgjson = pattern_hit(PAT_IS_CFGJSON);
		is_logs    = pattern_hit(PAT_IS_LOGS);
		is_tables  = pattern_hit(PAT_IS_TABLES);
		case (o)
			OP_LIST: begin
				if (is_logs || is_tables)
					return RSN_OK;
				return in_config ? RSN_TIER2_CONFIG : RSN_NOT_LISTABLE;
			end
			OP_READ: begin
				if (in_logs)
					return RSN_OK;
				return in_config ? RSN_TIER2_CONFIG : RSN_READ_LIMIT;
			end
			OP_WRITE: begin
				if (in_tables || is_cfgjson)
					return RSN_OK;
				return in_logs ? RSN_LOG_WRITE : RSN_WRITE_LIMIT;
			end
			default: return in_logs ? RSN_OK : RSN_DELETE_LIMIT;
		endcase
	endfunction

	// Compare one accepted verdict beat with the oldest waiting verdict.
	task automatic check_verdict();
		reason_t want;
		if (verdict_q.size() == 0) begin
			report($sformatf("verdict beat with no path waiting: allowed=%0b reason=%0d",
				allowed, reason));
		end else begin
			want = verdict_q.pop_front();
			verdicts++;
			reasons_seen[want] = 1'b1;
			if (allowed !== (want == RSN_OK))
				report($sformatf("verdict %0d: allowed=%0b, expected %0b",
					verdicts, allowed, want == RSN_OK));
			if (reason !== want)
				report($sformatf("verdict %0d: reason=%0d, expected %0d (%s)",
					verdicts, reason, want, want.name()));
		end
	endtask

	// Both channels are sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_path();
			verdict_q.delete();
			pending      = 0;
			reasons_seen = '0;
		end else begin
			if (out_valid && !out_stall)
				check_verdict();
			if (in_valid && !in_stall) begin
				if (has_byte)
					absorb_byte(path_byte);
				if (last) begin
					verdict_q.push_back(judge_path(op_t'(op)));
					clear_path();
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

// ===== tb/path_policy_checker_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_policy_checker_top_tb: stimulus and verdict for the path checker
// Streams directed and random paths into the block one byte per beat with
// random gaps and random back-pressure on the verdict channel; a scoreboard
// beside the block predicts and checks every verdict.
// ----------------------------------------------------------------------------
module path_policy_checker_top_tb;
	import ppc_pkg::*;

	localparam int MAX_LEN = 127;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  path_byte = '0;
	logic        has_byte  = 1'b0;
	logic        last      = 1'b0;
	logic [1:0]  op        = OP_LIST;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        allowed;
	logic [3:0]  reason;

	int          errors;
	int          pending;
	int          verdicts;
	logic [13:0] reasons_seen;

	// Bytes of the path being built, and run bookkeeping.
	logic [7:0] path_q[$];
	int         beats_sent = 0;
	int         paths_sent = 0;
	int         drains     = 0;
	logic       no_gaps    = 1'b0;
	int         stall_left = 0;
	int         free_left  = 0;

	path_policy_checker_top #(
		.MAX_PATH_LEN(MAX_LEN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.path_byte(path_byte),
		.has_byte (has_byte),
		.last     (last),
		.op       (op),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.allowed  (allowed),
		.reason   (reason)
	);

	path_policy_checker_chk #(
		.MAX_PATH_LEN(MAX_LEN)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.path_byte   (path_byte),
		.has_byte    (has_byte),
		.last        (last),
		.op          (op),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.allowed     (allowed),
		.reason      (reason),
		.errors      (errors),
		.pending     (pending),
		.verdicts    (verdicts),
		.reasons_seen(reasons_seen)
	);

	always #1 clk = ~clk;

	// Hard limit on the run.
	initial begin
		#1_000_000;
		$display("Timeout: verdicts still outstanding at the simulation limit");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Verdict back-pressure: short stalls, some long ones, some clean stretches.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (free_left > 0) begin
				free_left--;
			end else begin
				case ($urandom_range(0, 19))
					0, 1: free_left = $urandom_range(50, 200);
					2: stall_left = $urandom_range(10, 40);
					default: begin
						free_left  = $urandom_range(0, 6);
						stall_left = $urandom_range(1, 3);
					end
				endcase
			end
		end
	end

	// Idle cycles before a beat: mostly none, a few long.
	function automatic int sender_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Drive one beat; entered and left at a falling edge.
	task automatic send_beat(input logic [7:0] b, input logic h, input logic l,
			input op_t o);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		path_byte <= b;
		has_byte  <= h;
		last      <= l;
		op        <= o;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (h || l)
			beats_sent++;
	endtask

	// Send the bytes in path_q; the path ends on its last byte or on a
	// separate beat that carries no byte. Ignored beats are mixed in.
	task automatic send_path(input op_t o);
		int   i;
		logic tail;
		tail = (path_q.size() == 0) || ($urandom_range(0, 4) == 0);
		for (i = 0; i < path_q.size(); i++) begin
			if ($urandom_range(0, 24) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0, op_t'($urandom_range(0, 3)));
			send_beat(path_q[i], 1'b1, !tail && i == path_q.size() - 1,
				(!tail && i == path_q.size() - 1) ? o : op_t'($urandom_range(0, 3)));
		end
		if (tail)
			send_beat(8'($urandom), 1'b0, 1'b1, o);
		paths_sent++;
	endtask

	// Hold the sender until every verdict has come out.
	task automatic drain_verdicts();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		drains++;
	endtask

	task automatic append_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			path_q.push_back(s[i]);
	endtask

	task automatic load_text(input string s);
		path_q.delete();
		append_text(s);
	endtask

	// A byte for a segment name: mostly printable, sometimes space or high.
	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'($urandom_range(97, 122));
		if (r < 55)
			return 8'($urandom_range(65, 90));
		if (r < 70)
			return 8'($urandom_range(48, 57));
		if (r < 78)
			return CH_DOT;
		if (r < 83)
			return "-";
		if (r < 87)
			return "_";
		if (r < 89)
			return "~";
		if (r < 92)
			return CH_SPACE;
		return 8'($urandom_range(128, 255));
	endfunction

	// One segment, with dot-only names now and then.
	task automatic append_segment();
		int r;
		int n;
		int i;
		r = $urandom_range(0, 99);
		if (r < 8)
			append_text("..");
		else if (r < 13)
			append_text(".");
		else if (r < 17)
			append_text("...");
		else if (r < 20)
			append_text("..a");
		else if (r < 23)
			append_text("a..");
		else begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				path_q.push_back(name_char());
		end
	endtask

	// A well-formed path on one of the policy prefixes or a near miss.
	task automatic build_normal();
		int n;
		int i;
		case ($urandom_range(0, 15))
			0, 1: load_text("/logs/");
			2, 3: load_text("/tables/");
			4, 5: load_text("/config/");
			6, 7: load_text("/config.json");
			8:    load_text("/");
			9:    load_text("/logs");
			10:   load_text("/tables");
			11:   load_text("/config");
			12:   load_text("/logz/");
			13:   load_text("/table/");
			14:   load_text("/config.jsn");
			default: load_text("/configs/");
		endcase
		n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
		for (i = 0; i < n; i++) begin
			if (path_q[$] != CH_SLASH)
				path_q.push_back(CH_SLASH);
			append_segment();
		end
		if (n > 0 && path_q[$] != CH_SLASH && $urandom_range(0, 3) == 0)
			path_q.push_back(CH_SLASH);
	endtask

	// A well-formed path with one or two faults planted in it.
	task automatic build_faulty();
		int n;
		int k;
		int pos;
		build_normal();
		n = $urandom_range(1, 2);
		for (k = 0; k < n; k++) begin
			pos = (path_q.size() > 1) ? $urandom_range(1, path_q.size() - 1) : 0;
			case ($urandom_range(0, 5))
				0: path_q[pos] = CH_BACKSLASH;
				1: path_q[pos] = 8'($urandom_range(0, 31));
				2: path_q[pos] = CH_DEL;
				3, 4: begin
					path_q.insert(pos, CH_SLASH);
					path_q.insert(pos, CH_SLASH);
				end
				default: path_q[0] = 8'($urandom);
			endcase
		end
	endtask

	// Short run of arbitrary bytes, rooted half of the time.
	task automatic build_noise();
		int n;
		int i;
		path_q.delete();
		n = $urandom_range(1, 8);
		for (i = 0; i < n; i++)
			path_q.push_back(8'($urandom));
		if ($urandom_range(0, 1) == 0)
			path_q[0] = CH_SLASH;
	endtask

	// A clean path of n bytes under a listable prefix.
	task automatic build_long(input int n);
		if ($urandom_range(0, 1) == 0)
			load_text("/logs/");
		else
			load_text("/tables/");
		while (path_q.size() < n) begin
			if (path_q[$] != CH_SLASH && $urandom_range(0, 5) == 0)
				path_q.push_back(CH_SLASH);
			else
				path_q.push_back(8'($urandom_range(97, 122)));
		end
	endtask

	// Stimulus.
	initial begin
		int target;
		int r;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed paths: each byte-level check, traversal, each operation and most denials.
		path_q.delete();
		send_path(OP_LIST);
		load_text("\\x");
		send_path(OP_WRITE);
		load_text("/a\\");
		send_path(OP_WRITE);
		load_text("/");
		path_q.push_back(8'h00);
		send_path(OP_DELETE);
		load_text("/x");
		path_q.push_back(CH_DEL);
		send_path(OP_LIST);
		load_text("/a//b");
		send_path(OP_READ);
		load_text("/logs/..");
		send_path(OP_READ);
		load_text("/");
		send_path(OP_LIST);
		load_text("/config/");
		send_path(OP_LIST);
		load_text("/logs/");
		send_path(OP_LIST);
		load_text("/tables/t");
		send_path(OP_WRITE);
		load_text("/config.json");
		send_path(OP_WRITE);
		load_text("/logs/a/");
		send_path(OP_WRITE);
		load_text("/logs/a/");
		send_path(OP_DELETE);
		load_text("/tables/");
		path_q.push_back(8'hFF);
		send_path(OP_READ);
		load_text("/tables/");
		send_path(OP_DELETE);
		drain_verdicts();

		// Length limit on both sides and counter saturation.
		build_long(MAX_LEN);
		send_path(OP_DELETE);
		build_long(MAX_LEN + 1);
		send_path(OP_READ);
		build_long(300);
		send_path(OP_LIST);
		drain_verdicts();

		// Random paths, mostly well-formed with random content.
		target = beats_sent + 1300;
		while (beats_sent < target) begin
			no_gaps = ($urandom_range(0, 6) == 0);
			r = $urandom_range(0, 99);
			if (r < 62)
				build_normal();
			else if (r < 80)
				build_faulty();
			else if (r < 95)
				build_noise();
			else if (r < 97)
				build_long(($urandom_range(0, 9) == 0) ? $urandom_range(250, 300)
					: $urandom_range(120, 140));
			else
				path_q.delete();
			send_path(op_t'($urandom_range(0, 3)));
			if ($urandom_range(0, 49) == 0)
				drain_verdicts();
		end

		// Let the last verdicts out, then keep idling to catch stray beats.
		in_valid <= 1'b0;
		for (r = 0; r < 5000 && pending != 0; r++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (pending != 0)
			$display("Missing: %0d verdicts never arrived", pending);

		$display("Covered %0d paths in %0d beats, %0d verdicts checked, %0d drain pauses",
			paths_sent, beats_sent, verdicts, drains);
		$display("Reason codes exercised: %0d of 14", $countones(reasons_seen));
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
